// File: rtl/fbcw_pkg.sv
`default_nettype none
package fbcw_pkg;

  localparam logic [7:0]  START_BYTE = 8'hAA;
  localparam logic [31:0] CRC_POLY   = 32'h04C11DB7;
  localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;
  localparam logic [23:0] WORD_FILL  = 24'hFFFFFF;
  localparam logic [7:0]  PAD_BYTE   = 8'hFF;

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = 2;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_TIME = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_TYPE = 1'b1;

  localparam logic [2:0] HDR_IDX_START = 3'd0;
  localparam logic [2:0] HDR_IDX_TIME0 = 3'd1;
  localparam logic [2:0] HDR_IDX_TIME1 = 3'd2;
  localparam logic [2:0] HDR_IDX_TIME2 = 3'd3;
  localparam logic [2:0] HDR_IDX_TIME3 = 3'd4;
  localparam logic [2:0] HDR_IDX_TYPE  = 3'd5;
  localparam logic [2:0] CRC_IDX_LAST  = 3'd3;

  // One request from the front to the back.
  typedef struct packed {
    logic       hdr;
    logic       emit;
    logic       crc;
    logic       too_long;
    logic [7:0] data;
  } cmd_t;

  // Eight MSB-first shift steps of the CRC register.
  function automatic logic [31:0] crc_step8(input logic [31:0] c_in);
    logic [31:0] c;
    c = c_in;
    for (int i = 0; i < 8; i++) begin
      if (c[31]) begin
        c = {c[30:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[30:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: rtl/frame_builder_crc32_word_core.sv
`default_nettype none
// Frame builder: each accepted payload byte request leaves as framed bytes on
// the result queue, one byte per clock when pop is held high. The first request
// of a frame is preceded by six header bytes (0xAA, frame_time little-endian,
// frame_type); a last or empty request is followed by the four CRC bytes, CRC-32
// poly 0x04C11DB7, init all ones, no final XOR, over little-endian 32-bit words
// with 0xFF padding. Input requests are taken one per cycle, while full is low,
// into a four-entry request queue; the output side then runs one byte per cycle
// while pop is held high, and pauses before the CRC bytes while the word CRC
// unit (8 bits per cycle) settles; each frame adds 10 bytes to its payload.
// Payload beyond MAX_FRAME_BYTES - 10 bytes is dropped and too_long is set on
// the final CRC byte. Configuration writes are taken at any time (cfg_ready is
// always high) but must only be issued while the block is idle.
module frame_builder_crc32_word_core #(
  parameter int MAX_FRAME_BYTES = 128
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic [7:0]                     in_data,
  input  wire logic                           in_last,
  input  wire logic                           in_empty_req,
  output logic                                empty,
  input  wire logic                           pop,
  output logic [7:0]                          out_out_byte,
  output logic                                out_end_of_frame,
  output logic                                out_too_long,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [fbcw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                    cfg_data
);
  import fbcw_pkg::*;

  logic [31:0] frame_time_r;
  logic [7:0]  frame_type_r;
  logic        accept;
  logic        q_push;
  cmd_t        q_cmd;
  logic        q_full;
  logic        q_pop;
  logic        q_valid;
  cmd_t        q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_time_r <= '0;
      frame_type_r <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_TIME: frame_time_r <= cfg_data;
        REG_FRAME_TYPE: frame_type_r <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  assign full   = q_full;
  assign accept = push && !q_full;

  fbcw_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data      (in_data),
    .last      (in_last),
    .empty_req (in_empty_req),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  fbcw_cmd_q u_cmd_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_head)
  );

  fbcw_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_time   (frame_time_r),
    .frame_type   (frame_type_r),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .empty        (empty),
    .pop          (pop),
    .out_byte     (out_out_byte),
    .end_of_frame (out_end_of_frame),
    .too_long     (out_too_long)
  );

endmodule
`default_nettype wire

// File: rtl/fbcw_front.sv
`default_nettype none
module fbcw_front #(
  parameter int MAX_FRAME_BYTES = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  wire logic [7:0]  data,
  input  wire logic        last,
  input  wire logic        empty_req,
  output logic             q_push,
  output fbcw_pkg::cmd_t   q_cmd
);
  import fbcw_pkg::*;

  localparam int LIMIT = MAX_FRAME_BYTES - 10;
  localparam int CNT_W = $clog2(LIMIT + 1);
  localparam logic [CNT_W-1:0] LIMIT_C = CNT_W'(LIMIT);

  logic             in_frame_r, in_frame_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             overflow_r, overflow_nxt;
  logic             room;
  logic             drop;
  cmd_t             cmd;

  always_comb begin
    room         = count_r < LIMIT_C;
    drop         = !empty_req && !room;
    cmd.hdr      = !in_frame_r;
    cmd.emit     = !empty_req && room;
    cmd.crc      = empty_req || last;
    cmd.too_long = overflow_r || drop;
    cmd.data     = data;

    in_frame_nxt = in_frame_r;
    count_nxt    = count_r;
    overflow_nxt = overflow_r;
    if (accept) begin
      if (cmd.crc) begin
        in_frame_nxt = 1'b0;
        count_nxt    = '0;
        overflow_nxt = 1'b0;
      end else begin
        in_frame_nxt = 1'b1;
        if (cmd.emit) begin
          count_nxt = count_r + 1'b1;
        end
        overflow_nxt = overflow_r || drop;
      end
    end
  end

  // A dropped byte in an open frame that is not last yields no output, so nothing is queued.
  assign q_push = accept && (cmd.hdr || cmd.emit || cmd.crc);
  assign q_cmd  = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      count_r    <= '0;
      overflow_r <= 1'b0;
    end else begin
      in_frame_r <= in_frame_nxt;
      count_r    <= count_nxt;
      overflow_r <= overflow_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/fbcw_cmd_q.sv
`default_nettype none
module fbcw_cmd_q (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire fbcw_pkg::cmd_t  push_cmd,
  output logic                 full,
  input  wire logic            pop,
  output logic                 head_valid,
  output fbcw_pkg::cmd_t       head_cmd
);
  import fbcw_pkg::*;

  cmd_t               buf_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_AW:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign full       = count_r == (CMDQ_AW+1)'(CMDQ_DEPTH);
  assign head_valid = count_r != '0;
  assign head_cmd   = buf_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      buf_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/fbcw_back.sv
`default_nettype none
module fbcw_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [31:0]     frame_time,
  input  wire logic [7:0]      frame_type,
  input  wire logic            q_valid,
  input  wire fbcw_pkg::cmd_t  q_head,
  output logic                 q_pop,
  output logic                 empty,
  input  wire logic            pop,
  output logic [7:0]           out_byte,
  output logic                 end_of_frame,
  output logic                 too_long
);
  import fbcw_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_HDR  = 5'b00010,
    S_DATA = 5'b00100,
    S_CRCW = 5'b01000,
    S_CRC  = 5'b10000
  } state_t;

  state_t      state_r, state_nxt;
  logic [2:0]  idx_r, idx_nxt;
  cmd_t        cur_r, cur_nxt;
  logic [23:0] word_buf_r, word_buf_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [1:0]  steps_r, steps_nxt;
  logic [31:0] crc_hold_r, crc_hold_nxt;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_eof_r;
  logic        out_tl_r;

  logic        can_emit;
  logic        emit;
  logic [7:0]  emit_byte;
  logic        emit_eof;
  logic        emit_tl;
  logic        feed;
  logic        crc_load;
  logic        crc_clear;
  logic [31:0] load_word;
  logic [7:0]  hdr_byte;

  assign can_emit = !out_valid_r || pop;

  always_comb begin
    case (idx_r)
      HDR_IDX_START: hdr_byte = START_BYTE;
      HDR_IDX_TIME0: hdr_byte = frame_time[7:0];
      HDR_IDX_TIME1: hdr_byte = frame_time[15:8];
      HDR_IDX_TIME2: hdr_byte = frame_time[23:16];
      HDR_IDX_TIME3: hdr_byte = frame_time[31:24];
      HDR_IDX_TYPE:  hdr_byte = frame_type;
      default:       hdr_byte = START_BYTE;
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    cur_nxt      = cur_r;
    word_buf_nxt = word_buf_r;
    pos_nxt      = pos_r;
    crc_hold_nxt = crc_hold_r;
    q_pop        = 1'b0;
    emit         = 1'b0;
    emit_byte    = cur_r.data;
    emit_eof     = 1'b0;
    emit_tl      = 1'b0;
    feed         = 1'b0;
    crc_load     = 1'b0;
    crc_clear    = 1'b0;
    load_word    = {PAD_BYTE, word_buf_r};

    case (state_r)
      S_IDLE: begin
        state_nxt = S_IDLE;
      end
      S_HDR: begin
        if (can_emit) begin
          emit      = 1'b1;
          feed      = 1'b1;
          emit_byte = hdr_byte;
          idx_nxt   = idx_r + 1'b1;
          if (idx_r == HDR_IDX_TYPE) begin
            if (cur_r.emit) begin
              state_nxt = S_DATA;
            end else if (cur_r.crc) begin
              state_nxt = S_CRCW;
            end else begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      S_DATA: begin
        if (can_emit) begin
          emit      = 1'b1;
          feed      = 1'b1;
          emit_byte = cur_r.data;
          state_nxt = cur_r.crc ? S_CRCW : S_IDLE;
        end
      end
      S_CRCW: begin
        // Wait for the word unit, then flush the padded tail word.
        if (steps_r == '0) begin
          if (pos_r != '0) begin
            crc_load     = 1'b1;
            load_word    = {PAD_BYTE, word_buf_r};
            word_buf_nxt = WORD_FILL;
            pos_nxt      = '0;
          end else begin
            crc_hold_nxt = crc_r;
            crc_clear    = 1'b1;
            idx_nxt      = '0;
            state_nxt    = S_CRC;
          end
        end
      end
      S_CRC: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_byte = crc_hold_r[{idx_r[1:0], 3'b000} +: 8];
          idx_nxt   = idx_r + 1'b1;
          if (idx_r == CRC_IDX_LAST) begin
            emit_eof  = 1'b1;
            emit_tl   = cur_r.too_long;
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Take the next request as soon as the current one is done.
    if (state_nxt == S_IDLE && q_valid) begin
      q_pop   = 1'b1;
      cur_nxt = q_head;
      idx_nxt = '0;
      if (q_head.hdr) begin
        state_nxt = S_HDR;
      end else if (q_head.emit) begin
        state_nxt = S_DATA;
      end else begin
        state_nxt = S_CRCW;
      end
    end

    if (feed) begin
      if (pos_r == 2'd3) begin
        crc_load     = 1'b1;
        load_word    = {emit_byte, word_buf_r};
        word_buf_nxt = WORD_FILL;
        pos_nxt      = '0;
      end else begin
        word_buf_nxt[{pos_r, 3'b000} +: 8] = emit_byte;
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  // Word CRC unit: eight bit steps per cycle.
  always_comb begin
    crc_nxt   = crc_r;
    steps_nxt = steps_r;
    if (crc_load) begin
      crc_nxt   = crc_step8(crc_r ^ load_word);
      steps_nxt = 2'd3;
    end else if (crc_clear) begin
      crc_nxt = CRC_INIT;
    end else if (steps_r != '0) begin
      crc_nxt   = crc_step8(crc_r);
      steps_nxt = steps_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      word_buf_r  <= WORD_FILL;
      pos_r       <= '0;
      crc_r       <= CRC_INIT;
      steps_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      idx_r      <= idx_nxt;
      word_buf_r <= word_buf_nxt;
      pos_r      <= pos_nxt;
      crc_r      <= crc_nxt;
      steps_r    <= steps_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    crc_hold_r <= crc_hold_nxt;
    if (emit) begin
      out_byte_r <= emit_byte;
      out_eof_r  <= emit_eof;
      out_tl_r   <= emit_tl;
    end
  end

  assign empty        = !out_valid_r;
  assign out_byte     = out_byte_r;
  assign end_of_frame = out_eof_r;
  assign too_long     = out_tl_r;

`ifndef SYNTH
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    crc_load |-> steps_r == '0)
    else $error("word CRC unit loaded while busy");

  a_crc_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CRC |-> steps_r == '0 && pos_r == '0)
    else $error("CRC bytes sent with a word still pending");

  a_flush_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CRCW && steps_r == '0 && pos_r == '0) |=> state_r == S_CRC)
    else $error("CRC wait did not advance after flush");

  a_eof_tail: assert property (@(posedge clk) disable iff (!rst_n)
    emit_eof |-> state_r == S_CRC && idx_r == CRC_IDX_LAST)
    else $error("end of frame raised outside the last CRC byte");
`endif

endmodule
`default_nettype wire
